// ===== sv/mego_pkg.sv =====
// Shared types, codes and microcode table for the midpoint ellipse outline generator.
`default_nettype none

package mego_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 12;
    localparam int COORD_W = 12;
    localparam int SQ_W    = 22;
    localparam int ACC_W   = 36;
    localparam int DEC_W   = 50;
    localparam int MUL_W   = 24;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PC_W    = 4;
    localparam int PT_W    = 8 * COORD_W;

    // outline phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;

    // command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // microcode addresses
    localparam logic [PC_W-1:0] UA_WAIT = 4'd0;
    localparam logic [PC_W-1:0] UA_ST0  = 4'd1;
    localparam logic [PC_W-1:0] UA_ST1  = 4'd2;
    localparam logic [PC_W-1:0] UA_ST2  = 4'd3;
    localparam logic [PC_W-1:0] UA_ST3  = 4'd4;
    localparam logic [PC_W-1:0] UA_R1A  = 4'd5;
    localparam logic [PC_W-1:0] UA_R1B  = 4'd6;
    localparam logic [PC_W-1:0] UA_RC0  = 4'd7;
    localparam logic [PC_W-1:0] UA_RC1  = 4'd8;
    localparam logic [PC_W-1:0] UA_RC2  = 4'd9;
    localparam logic [PC_W-1:0] UA_RC3  = 4'd10;
    localparam logic [PC_W-1:0] UA_RC4  = 4'd11;
    localparam logic [PC_W-1:0] UA_RC5  = 4'd12;
    localparam logic [PC_W-1:0] UA_R2A  = 4'd13;
    localparam logic [PC_W-1:0] UA_R2B  = 4'd14;
    localparam logic [PC_W-1:0] UA_EMIT = 4'd15;

    // multiplier operand selects
    localparam logic [2:0] SEL_NONE = 3'd0;
    localparam logic [2:0] SEL_CX   = 3'd1;
    localparam logic [2:0] SEL_CY   = 3'd2;
    localparam logic [2:0] SEL_ASQ  = 3'd3;
    localparam logic [2:0] SEL_BSQ  = 3'd4;
    localparam logic [2:0] SEL_T    = 3'd5;
    localparam logic [2:0] SEL_U    = 3'd6;
    localparam logic [2:0] SEL_PROD = 3'd7;

    // decision variable operations
    localparam logic [2:0] DO_NONE = 3'd0;
    localparam logic [2:0] DO_INIT = 3'd1;
    localparam logic [2:0] DO_R1   = 3'd2;
    localparam logic [2:0] DO_R2   = 3'd3;
    localparam logic [2:0] DO_LOAD = 3'd4;
    localparam logic [2:0] DO_ADD4 = 3'd5;
    localparam logic [2:0] DO_SUB4 = 3'd6;

    // square register loads
    localparam logic [1:0] RG_NONE = 2'd0;
    localparam logic [1:0] RG_ASQ  = 2'd1;
    localparam logic [1:0] RG_BSQ  = 2'd2;

    // coordinate step operations
    localparam logic [1:0] SO_NONE  = 2'd0;
    localparam logic [1:0] SO_R1    = 2'd1;
    localparam logic [1:0] SO_R2    = 2'd2;
    localparam logic [1:0] SO_SETR2 = 2'd3;

    // sequencer branch operations
    localparam logic [2:0] BR_WAIT = 3'd0;
    localparam logic [2:0] BR_NEXT = 3'd1;
    localparam logic [2:0] BR_JMP  = 3'd2;
    localparam logic [2:0] BR_YZ   = 3'd3;
    localparam logic [2:0] BR_EMIT = 3'd4;

    typedef struct packed {
        logic            mul_en;
        logic [2:0]      asel;
        logic [2:0]      bsel;
        logic [2:0]      dec_op;
        logic [1:0]      reg_op;
        logic [1:0]      step_op;
        logic [2:0]      br_op;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   start_load;
        logic   out_load;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       px_lt_py;
        logic       y_zero;
    } stat_t;

    function automatic uword_t mk_uw(
        input logic            mul_en,
        input logic [2:0]      asel,
        input logic [2:0]      bsel,
        input logic [2:0]      dec_op,
        input logic [1:0]      reg_op,
        input logic [1:0]      step_op,
        input logic [2:0]      br_op,
        input logic [PC_W-1:0] target
    );
        uword_t w;
        w.mul_en  = mul_en;
        w.asel    = asel;
        w.bsel    = bsel;
        w.dec_op  = dec_op;
        w.reg_op  = reg_op;
        w.step_op = step_op;
        w.br_op   = br_op;
        w.target  = target;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            // a^2, b^2, a^2*b, then initial decision and py
            UA_ST0: w = mk_uw(1'b1, SEL_CX, SEL_CX, DO_NONE, RG_NONE, SO_NONE, BR_NEXT, UA_WAIT);
            UA_ST1: w = mk_uw(1'b1, SEL_CY, SEL_CY, DO_NONE, RG_ASQ, SO_NONE, BR_NEXT, UA_WAIT);
            UA_ST2: w = mk_uw(1'b1, SEL_ASQ, SEL_CY, DO_NONE, RG_BSQ, SO_NONE, BR_NEXT, UA_WAIT);
            UA_ST3: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_INIT, RG_NONE, SO_NONE, BR_JMP, UA_EMIT);
            // region 1 step
            UA_R1A: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_NONE, RG_NONE, SO_R1, BR_NEXT, UA_WAIT);
            UA_R1B: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_R1, RG_NONE, SO_NONE, BR_JMP, UA_EMIT);
            // region change: b2*t^2 + 4*a2*u^2 - 4*a2*b2
            UA_RC0: w = mk_uw(1'b1, SEL_T, SEL_T, DO_NONE, RG_NONE, SO_NONE, BR_NEXT, UA_WAIT);
            UA_RC1: w = mk_uw(1'b1, SEL_PROD, SEL_BSQ, DO_NONE, RG_NONE, SO_NONE, BR_NEXT, UA_WAIT);
            UA_RC2: w = mk_uw(1'b1, SEL_U, SEL_U, DO_LOAD, RG_NONE, SO_NONE, BR_NEXT, UA_WAIT);
            UA_RC3: w = mk_uw(1'b1, SEL_PROD, SEL_ASQ, DO_NONE, RG_NONE, SO_NONE, BR_NEXT, UA_WAIT);
            UA_RC4: w = mk_uw(1'b1, SEL_ASQ, SEL_BSQ, DO_ADD4, RG_NONE, SO_NONE, BR_NEXT, UA_WAIT);
            UA_RC5: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_SUB4, RG_NONE, SO_SETR2, BR_NEXT,
                              UA_WAIT);
            // region 2 step
            UA_R2A: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_NONE, RG_NONE, SO_R2, BR_YZ, UA_WAIT);
            UA_R2B: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_R2, RG_NONE, SO_NONE, BR_JMP, UA_EMIT);
            UA_EMIT: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_NONE, RG_NONE, SO_NONE, BR_EMIT,
                               UA_WAIT);
            default: w = mk_uw(1'b0, SEL_NONE, SEL_NONE, DO_NONE, RG_NONE, SO_NONE, BR_WAIT,
                               UA_WAIT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mego_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branching.
`default_nettype none

module mego_seq
    import mego_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_cmd,
    input  wire logic  out_free,
    input  wire stat_t stat,
    output logic       in_ready,
    output ctrl_t      ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            accept;

    assign uw       = ucode_rom(pc_reg);
    assign in_ready = (pc_reg == UA_WAIT);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pc_next         = pc_reg;
        ctrl.uw         = uw;
        ctrl.start_load = accept && (in_cmd == CMD_START);
        ctrl.out_load   = 1'b0;
        unique case (uw.br_op)
            BR_WAIT:
            begin
                // dispatch on the accepted command and the outline phase
                if (accept)
                begin
                    if (in_cmd == CMD_START)
                        pc_next = UA_ST0;
                    else if (stat.phase == PH_R1)
                        pc_next = stat.px_lt_py ? UA_R1A : UA_RC0;
                    else if (stat.phase == PH_R2)
                        pc_next = UA_R2A;
                    else
                        pc_next = UA_WAIT;
                end
            end
            BR_NEXT: pc_next = pc_reg + 1'b1;
            BR_JMP:  pc_next = uw.target;
            BR_YZ:   pc_next = stat.y_zero ? UA_WAIT : pc_reg + 1'b1;
            BR_EMIT:
            begin
                // hold until the output register can take the point set
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    pc_next       = UA_WAIT;
                end
            end
            default: pc_next = UA_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= UA_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

// ===== sv/mego_dp.sv =====
// Datapath: shared multiplier, ellipse state registers and outline point formation.
`default_nettype none

module mego_dp
    import mego_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctrl,
    input  wire logic [DIM_W-1:0]   box_width,
    input  wire logic [DIM_W-1:0]   box_height,
    output stat_t                   stat,
    output logic [PT_W-1:0]         pt_data,
    output logic                    pt_last
);

    logic [1:0]          phase_reg,  phase_next;
    logic [SQ_W-1:0]     asq_reg,    asq_next;
    logic [SQ_W-1:0]     bsq_reg,    bsq_next;
    logic [COORD_W-1:0]  x_reg,      x_next;
    logic [COORD_W-1:0]  y_reg,      y_next;
    logic [ACC_W-1:0]    px_reg,     px_next;
    logic [ACC_W-1:0]    py_reg,     py_next;
    logic signed [DEC_W-1:0] dec_reg, dec_next;
    logic [COORD_W-1:0]  cx_reg,     cx_next;
    logic [COORD_W-1:0]  cy_reg,     cy_next;
    logic [1:0]          even_reg,   even_next;
    logic [PROD_W-1:0]   prod_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [DIM_W-1:0]    w_clamp;
    logic [DIM_W-1:0]    h_clamp;
    logic [ACC_W-1:0]    two_a2;
    logic [ACC_W-1:0]    two_b2;
    logic signed [DEC_W-1:0] asq_e, bsq_e, px_e, py_e, prod_e, prod4_e, delta;
    logic                dec_neg;
    logic                dec_pos;
    logic [COORD_W-1:0]  rx, lx, ly, uy;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = v;
        if (d == '0)
            d = DIM_W'(1);
        if (int'(d) > MAX_DIM - 1)
            d = DIM_W'(MAX_DIM - 1);
        return d;
    endfunction

    function automatic logic [MUL_W-1:0] opnd(
        input logic [2:0]         sel,
        input logic [COORD_W-1:0] cx,
        input logic [COORD_W-1:0] cy,
        input logic [SQ_W-1:0]    asq,
        input logic [SQ_W-1:0]    bsq,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [PROD_W-1:0]  p
    );
        logic [MUL_W-1:0] r;
        case (sel)
            SEL_CX:   r = MUL_W'(cx);
            SEL_CY:   r = MUL_W'(cy);
            SEL_ASQ:  r = MUL_W'(asq);
            SEL_BSQ:  r = MUL_W'(bsq);
            SEL_T:    r = MUL_W'({x, 1'b1});
            SEL_U:    r = MUL_W'(y - 1'b1);
            SEL_PROD: r = p[MUL_W-1:0];
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign w_clamp = clamp_dim(box_width);
    assign h_clamp = clamp_dim(box_height);

    assign mul_a = opnd(ctrl.uw.asel, cx_reg, cy_reg, asq_reg, bsq_reg, x_reg, y_reg, prod_reg);
    assign mul_b = opnd(ctrl.uw.bsel, cx_reg, cy_reg, asq_reg, bsq_reg, x_reg, y_reg, prod_reg);

    assign two_a2  = ACC_W'({asq_reg, 1'b0});
    assign two_b2  = ACC_W'({bsq_reg, 1'b0});
    assign asq_e   = DEC_W'(asq_reg);
    assign bsq_e   = DEC_W'(bsq_reg);
    assign px_e    = DEC_W'(px_reg);
    assign py_e    = DEC_W'(py_reg);
    assign prod_e  = DEC_W'(prod_reg);
    assign prod4_e = DEC_W'({prod_reg, 2'b00});
    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);

    always_comb
    begin
        phase_next = phase_reg;
        asq_next   = asq_reg;
        bsq_next   = bsq_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        dec_next   = dec_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        even_next  = even_reg;
        delta      = '0;

        if (ctrl.start_load)
        begin
            cx_next    = COORD_W'(w_clamp[DIM_W-1:1]);
            cy_next    = COORD_W'(h_clamp[DIM_W-1:1]);
            even_next  = {~h_clamp[0], ~w_clamp[0]};
            x_next     = '0;
            y_next     = COORD_W'(h_clamp[DIM_W-1:1]);
            px_next    = '0;
            phase_next = PH_R1;
        end

        case (ctrl.uw.reg_op)
            RG_ASQ:  asq_next = prod_reg[SQ_W-1:0];
            RG_BSQ:  bsq_next = prod_reg[SQ_W-1:0];
            default: ;
        endcase

        case (ctrl.uw.step_op)
            SO_R1:
            begin
                x_next  = x_reg + 1'b1;
                px_next = px_reg + two_b2;
                if (!dec_neg)
                begin
                    y_next  = y_reg - 1'b1;
                    py_next = py_reg - two_a2;
                end
            end
            SO_R2:
            begin
                if (y_reg == '0)
                    phase_next = PH_IDLE;
                else
                begin
                    y_next  = y_reg - 1'b1;
                    py_next = py_reg - two_a2;
                    if (!dec_pos)
                    begin
                        x_next  = x_reg + 1'b1;
                        px_next = px_reg + two_b2;
                    end
                end
            end
            SO_SETR2: phase_next = PH_R2;
            default: ;
        endcase

        case (ctrl.uw.dec_op)
            DO_INIT:
            begin
                dec_next = (bsq_e <<< 2) + asq_e - prod4_e;
                py_next  = ACC_W'({prod_reg, 1'b0});
            end
            DO_R1:
            begin
                delta    = bsq_e + px_e - (dec_neg ? '0 : py_e);
                dec_next = dec_reg + (delta <<< 2);
            end
            DO_R2:
            begin
                delta    = asq_e - py_e + (dec_pos ? '0 : px_e);
                dec_next = dec_reg + (delta <<< 2);
            end
            DO_LOAD: dec_next = prod_e;
            DO_ADD4: dec_next = dec_reg + prod4_e;
            DO_SUB4: dec_next = dec_reg - prod4_e;
            default: ;
        endcase

        // the outline ends with the point set at y = 0
        if (ctrl.out_load && (y_reg == '0))
            phase_next = PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        asq_reg  <= asq_next;
        bsq_reg  <= bsq_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        dec_reg  <= dec_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        even_reg <= even_next;
        if (ctrl.uw.mul_en)
            prod_reg <= mul_a * mul_b;
    end

    assign rx = cx_reg + x_reg - COORD_W'(even_reg[0]);
    assign lx = cx_reg - x_reg;
    assign ly = cy_reg + y_reg - COORD_W'(even_reg[1]);
    assign uy = cy_reg - y_reg;

    assign pt_data = {uy, lx, uy, rx, ly, lx, ly, rx};
    assign pt_last = (y_reg == '0);

    assign stat.phase    = phase_reg;
    assign stat.px_lt_py = (px_reg < py_reg);
    assign stat.y_zero   = (y_reg == '0);

endmodule

`default_nettype wire

// ===== sv/midpoint_ellipse_outline_generator_core.sv =====
// Sequence: a start runs microcode steps ST0 to ST3 and EMIT, a region step R1A, R1B and EMIT
// (R2A, R2B in region 2), and the step that changes region RC0 to RC5, R2A, R2B and EMIT.
// The sequencer runs one command at a time through a single shared 24x24 multiplier and one
// decision adder and takes the next only in WAIT; an advance with no point goes straight back.
// Reset: rst_n clears the step counter, the outline phase and the output valid flag;
// after reset an advance gives no point until a start has been taken.
`default_nettype none

module midpoint_ellipse_outline_generator_core
    import mego_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [2*DIM_W-1:0]    s_axis_tdata,   // box_width, box_height
    input  wire logic [0:0]            s_axis_tuser,   // command
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [PT_W-1:0]            m_axis_tdata,   // right_lower_x, right_lower_y,
                                                       // left_lower_x, left_lower_y,
                                                       // right_upper_x, right_upper_y,
                                                       // left_upper_x, left_upper_y
    output logic                       m_axis_tlast    // last
);

    ctrl_t            ctrl;
    stat_t            stat;
    logic [PT_W-1:0]  pt_data;
    logic             pt_last;
    logic             out_free;

    logic             m_valid_reg, m_valid_next;
    logic [PT_W-1:0]  m_data_reg;
    logic             m_last_reg;

    // The output register frees up in the same cycle its transaction completes.
    assign out_free = !m_valid_reg || m_axis_tready;

    mego_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser[0]),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .ctrl     (ctrl)
    );

    mego_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .box_width  (s_axis_tdata[DIM_W-1:0]),
        .box_height (s_axis_tdata[2*DIM_W-1:DIM_W]),
        .stat       (stat),
        .pt_data    (pt_data),
        .pt_last    (pt_last)
    );

    // Hold the point set until the consumer takes it; load a new one on emit.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (ctrl.out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            m_data_reg <= pt_data;
            m_last_reg <= pt_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // The final point set of an outline must leave the generator idle.
    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.out_load && pt_last) |=> (stat.phase == PH_IDLE))
        else $error("outline still running after final point set");

    // A region 2 step at y = 0 ends the outline without a point set.
    a_r2_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.uw.step_op == SO_R2 && stat.y_zero) |=> (stat.phase == PH_IDLE && !ctrl.out_load))
        else $error("region 2 continued past y = 0");

    // A point set is only emitted into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> out_free)
        else $error("point set loaded over a pending transaction");

endmodule

`default_nettype wire
